### design/dagrmf_pkg.sv
// ----------------------------------------------------------------------------
// dagrmf_pkg
// Shared types, sizes and helpers for the reachable-minimum finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dagrmf_pkg;

	localparam int MAX_NODES  = 64;
	localparam int MAX_EDGES  = 256;
	localparam int VALUE_BITS = 16;

	localparam int NODE_W  = 6;
	localparam int CNT_W   = 7;
	localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ETOT_W  = $clog2(MAX_EDGES + 1);
	localparam int BEST_W  = VALUE_BITS + NODE_W;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_EDGE  = 2'd1,
		OP_RUN   = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [NODE_W-1:0]     node;
		logic [VALUE_BITS-1:0] value;
		logic [NODE_W-1:0]     upper_node;
		logic [NODE_W-1:0]     lower_node;
	} in_item_t;

	typedef struct packed {
		logic [NODE_W-1:0]     for_node;
		logic [NODE_W-1:0]     best_node;
		logic [VALUE_BITS-1:0] best_value;
		logic                  last;
		logic                  edge_error;
	} out_item_t;

	typedef struct packed {
		op_t                   op;
		logic [NODE_W-1:0]     node;
		logic [VALUE_BITS-1:0] value;
		logic [NODE_W-1:0]     upper_node;
		logic [NODE_W-1:0]     lower_node;
		logic                  edge_ok;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_head_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_PASS_START,
		ST_EDGE_RD,
		ST_BEST_RD,
		ST_RELAX,
		ST_PASS_END,
		ST_EMIT_RD,
		ST_EMIT_WR
	} back_state_t;

	// zero acts as one node, anything above the maximum as the maximum
	function automatic logic [CNT_W-1:0] nodes_in_use(input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] n;
		if (cnt == '0) begin
			n = CNT_W'(1);
		end else if (cnt > CNT_W'(MAX_NODES)) begin
			n = CNT_W'(MAX_NODES);
		end else begin
			n = cnt;
		end
		return n;
	endfunction

endpackage

### design/dagrmf_ram.sv
// ----------------------------------------------------------------------------
// dagrmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dagrmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/dagrmf_front.sv
// ----------------------------------------------------------------------------
// dagrmf_front
// Accepts items, classifies them and holds them in a short command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dagrmf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  dagrmf_pkg::in_item_t        request,
	input  logic [dagrmf_pkg::CNT_W-1:0] node_count,
	output dagrmf_pkg::cmd_head_t       head,
	input  logic                        cmd_pop
);

	import dagrmf_pkg::*;

	cmd_t               q_mem [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wptr_q;
	logic [CMDQ_AW-1:0] rptr_q;
	logic [CMDQ_AW:0]   cnt_q;
	logic [CNT_W-1:0]   n;
	cmd_t               cls;
	logic               do_push;
	logic               do_pop;

	assign n = nodes_in_use(node_count);

	always_comb begin
		cls.op         = request.op;
		cls.node       = request.node;
		cls.value      = request.value;
		cls.upper_node = request.upper_node;
		cls.lower_node = request.lower_node;
		cls.edge_ok    = ({1'b0, request.upper_node} < n) && ({1'b0, request.lower_node} < n);
	end

	assign full       = (cnt_q == (CMDQ_AW + 1)'(CMDQ_DEPTH));
	assign do_push    = push && !full;
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = q_mem[rptr_q];
	assign do_pop     = cmd_pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### design/dagrmf_back.sv
// ----------------------------------------------------------------------------
// dagrmf_back
// Executes commands: node and edge stores, relaxation runs, answer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dagrmf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [dagrmf_pkg::CNT_W-1:0] node_count,
	input  dagrmf_pkg::cmd_head_t        head,
	output logic                         cmd_pop,
	output logic                         empty,
	input  logic                         pop,
	output dagrmf_pkg::out_item_t        answer
);

	import dagrmf_pkg::*;

	back_state_t         state_q, state_d;
	logic [NODE_W-1:0]   i_q, i_d;
	logic [EDGE_AW-1:0]  e_q, e_d;
	logic [ETOT_W-1:0]   total_q, total_d;
	logic                dropped_q, dropped_d;
	logic                changed_q, changed_d;

	logic                init_rd;
	logic                init_v_s1;
	logic [NODE_W-1:0]   init_idx_s1;
	logic [NODE_W-1:0]   relax_lo_s1;
	logic                relax_ok_s1;
	logic                relax_we;

	logic [CNT_W-1:0]    n;
	logic                last_i;

	logic                      node_we;
	logic [VALUE_BITS-1:0]     node_rdata;
	logic                      edge_we;
	logic [2*NODE_W-1:0]       edge_rdata;
	logic [NODE_W-1:0]         edge_up;
	logic [NODE_W-1:0]         edge_lo;
	logic                      best_we;
	logic [NODE_W-1:0]         best_waddr;
	logic [BEST_W-1:0]         best_wdata;
	logic [NODE_W-1:0]         best_ra;
	logic [BEST_W-1:0]         best_a_rdata;
	logic [BEST_W-1:0]         best_b_rdata;

	out_item_t           outq_mem [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]  outq_wptr_q;
	logic [OUTQ_AW-1:0]  outq_rptr_q;
	logic [OUTQ_AW:0]    outq_cnt_q;
	logic                outq_full;
	logic                outq_push;
	logic                outq_pop;
	out_item_t           outq_item;

	assign n       = nodes_in_use(node_count);
	assign last_i  = ({1'b0, i_q} == n - CNT_W'(1));
	assign edge_up = edge_rdata[2*NODE_W-1:NODE_W];
	assign edge_lo = edge_rdata[NODE_W-1:0];

	dagrmf_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_NODES)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (head.cmd.node),
		.wdata (head.cmd.value),
		.raddr (i_q),
		.rdata (node_rdata)
	);

	dagrmf_ram #(.WIDTH(2 * NODE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (total_q[EDGE_AW-1:0]),
		.wdata ({head.cmd.upper_node, head.cmd.lower_node}),
		.raddr (e_q),
		.rdata (edge_rdata)
	);

	// two copies of the best store give one read port per edge end
	dagrmf_ram #(.WIDTH(BEST_W), .DEPTH(MAX_NODES)) u_best_a_ram (
		.clk   (clk),
		.we    (best_we),
		.waddr (best_waddr),
		.wdata (best_wdata),
		.raddr (best_ra),
		.rdata (best_a_rdata)
	);

	dagrmf_ram #(.WIDTH(BEST_W), .DEPTH(MAX_NODES)) u_best_b_ram (
		.clk   (clk),
		.we    (best_we),
		.waddr (best_waddr),
		.wdata (best_wdata),
		.raddr (edge_lo),
		.rdata (best_b_rdata)
	);

	assign best_we    = init_v_s1 || relax_we;
	assign best_waddr = init_v_s1 ? init_idx_s1 : relax_lo_s1;
	assign best_wdata = init_v_s1 ? {node_rdata, init_idx_s1} : best_a_rdata;

	always_comb begin
		state_d   = state_q;
		i_d       = i_q;
		e_d       = e_q;
		total_d   = total_q;
		dropped_d = dropped_q;
		changed_d = changed_q;
		cmd_pop   = 1'b0;
		node_we   = 1'b0;
		edge_we   = 1'b0;
		init_rd   = 1'b0;
		relax_we  = 1'b0;
		outq_push = 1'b0;
		best_ra   = i_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					cmd_pop = 1'b1;
					unique case (head.cmd.op)
						OP_LOAD: begin
							node_we = 1'b1;
						end
						OP_EDGE: begin
							if (head.cmd.edge_ok && (total_q != ETOT_W'(MAX_EDGES))) begin
								edge_we = 1'b1;
								total_d = total_q + 1'b1;
							end else begin
								dropped_d = 1'b1;
							end
						end
						OP_CLEAR: begin
							total_d   = '0;
							dropped_d = 1'b0;
						end
						OP_RUN: begin
							i_d     = '0;
							state_d = ST_INIT;
						end
					endcase
				end
			end
			ST_INIT: begin
				init_rd = 1'b1;
				if (last_i) begin
					state_d = ST_PASS_START;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			ST_PASS_START: begin
				changed_d = 1'b0;
				e_d       = '0;
				i_d       = '0;
				state_d   = (total_q == '0) ? ST_EMIT_RD : ST_EDGE_RD;
			end
			ST_EDGE_RD: begin
				state_d = ST_BEST_RD;
			end
			ST_BEST_RD: begin
				best_ra = edge_up;
				state_d = ST_RELAX;
			end
			ST_RELAX: begin
				if (relax_ok_s1 && (best_a_rdata < best_b_rdata)) begin
					relax_we  = 1'b1;
					changed_d = 1'b1;
				end
				if (ETOT_W'(e_q) == total_q - ETOT_W'(1)) begin
					state_d = ST_PASS_END;
				end else begin
					e_d     = e_q + 1'b1;
					state_d = ST_EDGE_RD;
				end
			end
			ST_PASS_END: begin
				i_d     = '0;
				state_d = changed_q ? ST_PASS_START : ST_EMIT_RD;
			end
			ST_EMIT_RD: begin
				if (!outq_full) begin
					state_d = ST_EMIT_WR;
				end
			end
			ST_EMIT_WR: begin
				outq_push = 1'b1;
				if (last_i) begin
					state_d = ST_IDLE;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			i_q       <= '0;
			e_q       <= '0;
			total_q   <= '0;
			dropped_q <= 1'b0;
			changed_q <= 1'b0;
			init_v_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			i_q       <= i_d;
			e_q       <= e_d;
			total_q   <= total_d;
			dropped_q <= dropped_d;
			changed_q <= changed_d;
			init_v_s1 <= init_rd;
		end
	end

	always_ff @(posedge clk) begin
		init_idx_s1 <= i_q;
		relax_lo_s1 <= edge_lo;
		relax_ok_s1 <= ({1'b0, edge_up} < n) && ({1'b0, edge_lo} < n);
	end

	// answer queue
	always_comb begin
		outq_item.for_node   = i_q;
		outq_item.best_node  = best_a_rdata[NODE_W-1:0];
		outq_item.best_value = best_a_rdata[BEST_W-1:NODE_W];
		outq_item.last       = last_i;
		outq_item.edge_error = dropped_q;
	end

	assign outq_full = (outq_cnt_q == (OUTQ_AW + 1)'(OUTQ_DEPTH));
	assign empty     = (outq_cnt_q == '0);
	assign answer    = outq_mem[outq_rptr_q];
	assign outq_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (outq_push) begin
			outq_mem[outq_wptr_q] <= outq_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outq_wptr_q <= '0;
			outq_rptr_q <= '0;
			outq_cnt_q  <= '0;
		end else begin
			if (outq_push) begin
				outq_wptr_q <= outq_wptr_q + 1'b1;
			end
			if (outq_pop) begin
				outq_rptr_q <= outq_rptr_q + 1'b1;
			end
			unique case ({outq_push, outq_pop})
				2'b10: outq_cnt_q <= outq_cnt_q + 1'b1;
				2'b01: outq_cnt_q <= outq_cnt_q - 1'b1;
				default: outq_cnt_q <= outq_cnt_q;
			endcase
		end
	end

endmodule

### design/dag_reachable_minimum_finder.sv
// ----------------------------------------------------------------------------
// dag_reachable_minimum_finder
// Loads node values and rank edges; on a run item answers, for each node in
// ascending order, the smallest-valued node reachable upward (ties to the
// lower index). Load, edge and clear items are executed back to back while no
// run is in progress, through a four-entry command queue. A run first seeds
// the best store from the node values, then makes passes over the E stored
// edges until a pass changes nothing (at most n passes; the passes are
// skipped when no edge is stored), then emits one answer per node, waiting
// while the answer queue is full. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dag_reachable_minimum_finder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  dagrmf_pkg::in_item_t         request,
	output logic                         empty,
	input  logic                         pop,
	output dagrmf_pkg::out_item_t        answer,
	input  logic                         node_count_we,
	input  logic [dagrmf_pkg::CNT_W-1:0] node_count_wdata
);

	import dagrmf_pkg::*;

	logic [CNT_W-1:0] node_count_q;
	cmd_head_t        head;
	logic             cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(MAX_NODES);
		end else if (node_count_we) begin
			node_count_q <= node_count_wdata;
		end
	end

	dagrmf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.request    (request),
		.node_count (node_count_q),
		.head       (head),
		.cmd_pop    (cmd_pop)
	);

	dagrmf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_count (node_count_q),
		.head       (head),
		.cmd_pop    (cmd_pop),
		.empty      (empty),
		.pop        (pop),
		.answer     (answer)
	);

	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> head.valid)
		else $error("command popped from an empty queue");

	a_answer_order: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !answer.last |=>
			empty || (answer.for_node == NODE_W'($past(answer.for_node) + 1'b1)))
		else $error("answers out of node order");

	a_answer_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && answer.last |=> empty || (answer.for_node == '0))
		else $error("run answers do not start at node zero");

endmodule

### tb/tb_dag_reachable_minimum_finder.sv
// ----------------------------------------------------------------------------
// tb_dag_reachable_minimum_finder
// Self-checking bench for the reachable-minimum finder. A behavioral copy of
// the node values, link list and error flag predicts every run's answers,
// which are checked in order as they leave the block. Directed tests cover
// ties, cycles, self links, dropped and stale links and node count extremes;
// a random part follows, with bursty input, a stalling receiver and one
// long hold-off that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dag_reachable_minimum_finder;

	import dagrmf_pkg::*;

	localparam int STALL_LIMIT  = 300000;
	localparam int SETTLE       = 16;
	localparam int RANDOM_ITEMS = 100;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	in_item_t              request;
	logic                  empty;
	logic                  pop;
	out_item_t             answer;
	logic                  node_count_we;
	logic [CNT_W-1:0]      node_count_wdata;

	// predictor state
	logic [CNT_W-1:0]      node_count_reg;
	logic [VALUE_BITS-1:0] node_val [MAX_NODES];
	bit                    loaded [MAX_NODES];
	logic [NODE_W-1:0]     link_upper [MAX_EDGES];
	logic [NODE_W-1:0]     link_lower [MAX_EDGES];
	int                    link_cnt;
	bit                    dropped;
	out_item_t             pending_answers [$];

	int errors;
	int items_sent;
	int runs_sent;
	int answers_checked;
	int cfg_writes;
	int links_dropped;
	int burst_left;
	int idle_cycles;
	int holdoff_count;
	int holdoff_len;

	dag_reachable_minimum_finder i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.request          (request),
		.empty            (empty),
		.pop              (pop),
		.answer           (answer),
		.node_count_we    (node_count_we),
		.node_count_wdata (node_count_wdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int unsigned active_nodes();
		if (node_count_reg == '0) begin
			return 1;
		end
		if (node_count_reg > CNT_W'(MAX_NODES)) begin
			return MAX_NODES;
		end
		return node_count_reg;
	endfunction

	// update the copy of the block state; a run queues its answers
	function automatic void apply_request(input in_item_t it);
		int unsigned n;
		bit changed;
		logic [BEST_W-1:0] best [MAX_NODES];
		out_item_t ans;
		n = active_nodes();
		case (it.op)
			OP_LOAD: begin
				node_val[it.node] = it.value;
				loaded[it.node] = 1'b1;
			end
			OP_EDGE: begin
				if (it.upper_node >= n || it.lower_node >= n || link_cnt >= MAX_EDGES) begin
					dropped = 1'b1;
					links_dropped++;
				end else begin
					link_upper[link_cnt] = it.upper_node;
					link_lower[link_cnt] = it.lower_node;
					link_cnt++;
				end
			end
			OP_CLEAR: begin
				link_cnt = 0;
				dropped = 1'b0;
			end
			default: begin
				for (int i = 0; i < n; i++) begin
					best[i] = {node_val[i], NODE_W'(i)};
				end
				// relax until stable; value first, index breaks ties
				do begin
					changed = 1'b0;
					for (int e = 0; e < link_cnt; e++) begin
						if (link_upper[e] < n && link_lower[e] < n &&
						    best[link_upper[e]] < best[link_lower[e]]) begin
							best[link_lower[e]] = best[link_upper[e]];
							changed = 1'b1;
						end
					end
				end while (changed);
				for (int i = 0; i < n; i++) begin
					ans.for_node   = NODE_W'(i);
					ans.best_node  = best[i][NODE_W-1:0];
					ans.best_value = best[i][BEST_W-1:NODE_W];
					ans.last       = (i == n - 1);
					ans.edge_error = dropped;
					pending_answers = {pending_answers, ans};
				end
				runs_sent++;
			end
		endcase
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		it.op         = op_t'($urandom_range(0, 3));
		it.node       = NODE_W'($urandom);
		it.value      = VALUE_BITS'($urandom);
		it.upper_node = NODE_W'($urandom);
		it.lower_node = NODE_W'($urandom);
		return it;
	endfunction

	function automatic logic [VALUE_BITS-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return VALUE_BITS'($urandom_range(0, 3));
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	function automatic in_item_t load_item(input int nd, input logic [VALUE_BITS-1:0] v);
		in_item_t it;
		it = rand_item();
		it.op = OP_LOAD;
		it.node = NODE_W'(nd);
		it.value = v;
		return it;
	endfunction

	function automatic in_item_t link_item(input int up, input int lo);
		in_item_t it;
		it = rand_item();
		it.op = OP_EDGE;
		it.upper_node = NODE_W'(up);
		it.lower_node = NODE_W'(lo);
		return it;
	endfunction

	function automatic in_item_t cmd_item(input op_t op);
		in_item_t it;
		it = rand_item();
		it.op = op;
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		if (burst_left <= 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(1, 8);
		end
		push <= 1'b1;
		request <= it;
		do @(posedge clk); while (full);
		burst_left--;
		items_sent++;
		apply_request(it);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
	endtask

	task automatic set_node_count(input int v);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		node_count_we <= 1'b1;
		node_count_wdata <= CNT_W'(v);
		@(posedge clk);
		node_count_we <= 1'b0;
		node_count_reg = CNT_W'(v);
		cfg_writes++;
	endtask

	// a run must never read a node value that was never loaded
	task automatic run_all();
		for (int i = 0; i < active_nodes(); i++) begin
			if (!loaded[i]) begin
				send_item(load_item(i, rand_value()));
			end
		end
		send_item(cmd_item(OP_RUN));
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// answer checker and receiver stall pattern
	initial begin
		out_item_t want;
		int mode;
		int mode_left;
		int hold_left;
		int holdoff_seen;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		holdoff_seen = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (pending_answers.size() == 0) begin
					$error("answer for node %0d with none expected", answer.for_node);
					errors++;
				end else begin
					want = pending_answers.pop_front();
					check_field("for_node", want.for_node, answer.for_node);
					check_field("best_node", want.best_node, answer.best_node);
					check_field("best_value", want.best_value, answer.best_value);
					check_field("last", want.last, answer.last);
					check_field("edge_error", want.edge_error, answer.edge_error);
					answers_checked++;
				end
			end
			if (holdoff_count != holdoff_seen) begin
				holdoff_seen = holdoff_count;
				hold_left = holdoff_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				if (mode_left <= 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					default: pop <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("stalled for %0d cycles", idle_cycles);
				$display("tb_dag_reachable_minimum_finder: errors");
				$finish;
			end
		end
	end

	// ties, cycles, self link, dropped links and clear on four nodes
	task automatic test_basics();
		set_node_count(4);
		send_item(load_item(0, 16'd7));
		send_item(load_item(1, '1));
		send_item(load_item(2, 16'd7));
		send_item(load_item(3, '0));
		send_item(load_item(63, 16'h1234));
		send_item(link_item(2, 0));
		send_item(link_item(0, 2));
		send_item(link_item(3, 1));
		send_item(link_item(1, 3));
		send_item(link_item(1, 1));
		send_item(link_item(63, 0));
		send_item(link_item(0, 63));
		send_item(cmd_item(OP_RUN));
		send_item(cmd_item(OP_CLEAR));
		send_item(cmd_item(OP_RUN));
		send_item(link_item(3, 0));
		send_item(cmd_item(OP_RUN));
	endtask

	task automatic test_count_extremes();
		set_node_count(0);
		send_item(link_item(0, 0));
		send_item(link_item(0, 1));
		run_all();
		send_item(cmd_item(OP_CLEAR));
		set_node_count(127);
		for (int i = 0; i < 6; i++) begin
			send_item(link_item($urandom_range(0, 63), $urandom_range(0, 63)));
		end
		run_all();
		set_node_count(65);
		send_item(link_item(63, 62));
		run_all();
		set_node_count(1);
		run_all();
	endtask

	// links left over from a larger node count must be ignored
	task automatic test_stale_links();
		set_node_count(64);
		send_item(cmd_item(OP_CLEAR));
		send_item(load_item(40, '0));
		send_item(link_item(40, 5));
		send_item(link_item(5, 50));
		send_item(link_item(2, 3));
		send_item(link_item(63, 62));
		run_all();
		set_node_count(10);
		run_all();
		send_item(link_item(9, 0));
		send_item(link_item(10, 0));
		run_all();
		send_item(cmd_item(OP_CLEAR));
	endtask

	// receiver holds off while runs and loads keep coming, so input backs up
	task automatic test_backpressure();
		set_node_count(64);
		for (int i = 0; i < 8; i++) begin
			send_item(link_item($urandom_range(0, 63), $urandom_range(0, 63)));
		end
		holdoff_len = 600;
		holdoff_count++;
		run_all();
		send_item(cmd_item(OP_RUN));
		for (int i = 0; i < 8; i++) begin
			send_item(load_item($urandom_range(0, 63), rand_value()));
		end
		send_item(cmd_item(OP_RUN));
		send_item(cmd_item(OP_CLEAR));
	endtask

	task automatic test_random();
		int start;
		int n;
		int pick;
		in_item_t it;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				set_node_count($urandom_range(1, 12));
			end else if (pick < 8) begin
				set_node_count($urandom_range(13, 64));
			end else begin
				set_node_count($urandom_range(0, 127));
			end
			n = active_nodes();
			repeat ($urandom_range(10, 40)) begin
				pick = $urandom_range(0, 99);
				if (pick < 30) begin
					send_item(load_item(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
					                                               : $urandom_range(0, n - 1),
					                    rand_value()));
				end else if (pick < 65) begin
					if ($urandom_range(0, 6) == 0) begin
						send_item(link_item($urandom_range(0, 63), $urandom_range(0, 63)));
					end else begin
						send_item(link_item($urandom_range(0, n - 1), $urandom_range(0, n - 1)));
					end
				end else if (pick < 85) begin
					run_all();
				end else if (pick < 92) begin
					send_item(cmd_item(OP_CLEAR));
				end else begin
					it = rand_item();
					if (it.op == OP_RUN) begin
						run_all();
					end else begin
						send_item(it);
					end
				end
			end
			run_all();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		request <= '0;
		node_count_we <= 1'b0;
		node_count_wdata <= '0;
		node_count_reg = CNT_W'(MAX_NODES);
		link_cnt = 0;
		dropped = 1'b0;
		errors = 0;
		items_sent = 0;
		runs_sent = 0;
		answers_checked = 0;
		cfg_writes = 0;
		links_dropped = 0;
		burst_left = 0;
		holdoff_count = 0;
		holdoff_len = 0;
		for (int i = 0; i < MAX_NODES; i++) begin
			loaded[i] = 1'b0;
			node_val[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basics();
		test_count_extremes();
		test_stale_links();
		test_backpressure();
		test_random();

		wait_drained();
		repeat (50) @(posedge clk);
		$display("covered %0d items, %0d runs, %0d answers checked", items_sent, runs_sent,
		         answers_checked);
		$display("%0d node count writes, %0d links dropped", cfg_writes, links_dropped);
		if (errors == 0 && pending_answers.size() == 0) begin
			$display("tb_dag_reachable_minimum_finder: clean");
		end else begin
			$display("tb_dag_reachable_minimum_finder: errors");
		end
		$finish;
	end

endmodule
